// ===== rtl/core/infix_to_postfix_converter_assert.svh =====
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// checked only out of reset
`define IP2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IP2P_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ip2p_pkg.sv =====
package ip2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] din;
  } cell_ctl_t;

  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    if (ch == CH_LPAREN) p = 2'd0;
    else if (ch == CH_PLUS || ch == CH_MINUS) p = 2'd1;
    else if (ch == CH_STAR || ch == CH_SLASH || ch == CH_CARET) p = 2'd2;
    else p = 2'd3;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h30 && ch <= 8'h39);
  endfunction

endpackage

// ===== rtl/core/ip2p_if.sv =====
interface ip2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_expr;

  modport source (output valid, output in_char, output end_of_expr, input ready);
  modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface ip2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       expr_last;
  logic [1:0] error_code;

  modport source (output valid, output out_char, output char_valid, output expr_last,
                  output error_code, input ready);
  modport sink (input valid, input out_char, input char_valid, input expr_last,
                input error_code, output ready);
endinterface

// ===== rtl/core/ip2p_cell.sv =====
module ip2p_cell (
  input  logic                 clk,
  input  ip2p_pkg::cell_ctl_t  ctl,
  input  logic [7:0]           up_data,
  input  logic [7:0]           down_data,
  output logic [7:0]           data_r
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      ip2p_pkg::OP_PUSH: data_r <= up_data;
      ip2p_pkg::OP_POP:  data_r <= down_data;
      default:           data_r <= data_r;
    endcase
  end

endmodule

// ===== rtl/core/ip2p_stack.sv =====
module ip2p_stack #(
  parameter int STACK_DEPTH = ip2p_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  ip2p_pkg::cell_ctl_t ctl,
  output logic [7:0]          top,
  output logic [7:0]          below
);

  logic [7:0] cell_q [STACK_DEPTH];

  // cell 0 is the top of stack; push shifts down, pop shifts up
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up_d;
    logic [7:0] down_d;

    if (i == 0) begin : g_first
      assign up_d = ctl.din;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = cell_q[i];
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end

    ip2p_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_d),
      .down_data (down_d),
      .data_r    (cell_q[i])
    );
  end

  assign top   = cell_q[0];
  assign below = cell_q[1];

endmodule

// ===== rtl/core/ip2p_seq.sv =====
module ip2p_seq #(
  parameter int STACK_DEPTH = ip2p_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ip2p_in_if.sink             in_chan,
  ip2p_out_if.source          out_chan,
  input  logic [7:0]          top,
  input  logic [7:0]          below,
  output ip2p_pkg::cell_ctl_t ctl
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAIN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam logic [1:0] K_ALNUM = 2'd0;
  localparam logic [1:0] K_LP    = 2'd1;
  localparam logic [1:0] K_RP    = 2'd2;
  localparam logic [1:0] K_OP    = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          emitted_r, emitted_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lp_cnt_r, lp_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          char_valid_r, char_valid_nxt;
  logic          expr_last_r, expr_last_nxt;
  logic [1:0]    err_out_r, err_out_nxt;

  logic       can_go, full, empty, one_left, two_left;
  logic [1:0] top_prec, in_prec;
  logic       emit;
  logic [7:0] e_char;
  logic       e_cv, e_last;
  logic       do_push, do_pop;

  assign full     = count_r == CW'(STACK_DEPTH);
  assign empty    = count_r == '0;
  assign one_left = count_r == CW'(1);
  assign two_left = count_r == CW'(2);
  assign top_prec = ip2p_pkg::prec_of(top);
  assign in_prec  = ip2p_pkg::prec_of(in_chan.in_char);
  assign can_go   = !out_valid_r || out_chan.ready;

  assign in_chan.ready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    ch_nxt      = ch_r;
    last_nxt    = last_r;
    err_nxt     = err_r;
    emitted_nxt = emitted_r;
    lp_cnt_nxt  = lp_cnt_r;
    emit        = 1'b0;
    e_char      = 8'h00;
    e_cv        = 1'b1;
    e_last      = 1'b0;
    do_push     = 1'b0;
    do_pop      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          ch_nxt      = in_chan.in_char;
          last_nxt    = in_chan.end_of_expr;
          emitted_nxt = 1'b0;
          err_nxt     = ip2p_pkg::ERR_NONE;
          state_nxt   = S_MAIN;
          if (ip2p_pkg::is_alnum(in_chan.in_char)) begin
            kind_nxt = K_ALNUM;
          end else if (in_chan.in_char == ip2p_pkg::CH_LPAREN) begin
            kind_nxt = K_LP;
            if (full) err_nxt = ip2p_pkg::ERR_OVERFLOW;
          end else if (in_chan.in_char == ip2p_pkg::CH_RPAREN) begin
            kind_nxt = K_RP;
            if (lp_cnt_r == '0) err_nxt = ip2p_pkg::ERR_UNMATCHED;
          end else begin
            kind_nxt = K_OP;
            // a full stack stays full only if nothing gets popped first
            if (full && in_prec > top_prec) err_nxt = ip2p_pkg::ERR_OVERFLOW;
          end
        end
      end
      S_MAIN: begin
        if (can_go) begin
          case (kind_r)
            K_ALNUM: begin
              emit      = 1'b1;
              e_char    = ch_r;
              e_last    = last_r && empty;
              state_nxt = S_FLUSH;
            end
            K_LP: begin
              if (!full) begin
                do_push    = 1'b1;
                lp_cnt_nxt = lp_cnt_r + CW'(1);
              end
              state_nxt = S_FLUSH;
            end
            K_RP: begin
              if (empty) begin
                state_nxt = S_FLUSH;
              end else begin
                do_pop = 1'b1;
                if (top == ip2p_pkg::CH_LPAREN) begin
                  lp_cnt_nxt = lp_cnt_r - CW'(1);
                  state_nxt  = S_FLUSH;
                end else begin
                  emit   = 1'b1;
                  e_char = top;
                  // final if nothing or only a matching '(' is left beneath
                  e_last = last_r &&
                           (one_left || (two_left && below == ip2p_pkg::CH_LPAREN));
                end
              end
            end
            default: begin
              if (!empty && ip2p_pkg::prec_of(ch_r) <= top_prec) begin
                do_pop = 1'b1;
                emit   = 1'b1;
                e_char = top;
              end else begin
                do_push   = !full;
                state_nxt = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (can_go) begin
          if (last_r && !empty) begin
            do_pop = 1'b1;
            emit   = 1'b1;
            e_char = top;
            e_last = one_left;
            if (top == ip2p_pkg::CH_LPAREN) lp_cnt_nxt = lp_cnt_r - CW'(1);
            if (one_left) state_nxt = S_IDLE;
          end else begin
            if (!emitted_r && (last_r || err_r != ip2p_pkg::ERR_NONE)) begin
              emit   = 1'b1;
              e_cv   = 1'b0;
              e_last = last_r;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_char_nxt   = out_char_r;
    char_valid_nxt = char_valid_r;
    expr_last_nxt  = expr_last_r;
    err_out_nxt    = err_out_r;
    ctl.op         = ip2p_pkg::OP_HOLD;
    ctl.din        = ch_r;
    if (do_push) begin
      ctl.op    = ip2p_pkg::OP_PUSH;
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      ctl.op    = ip2p_pkg::OP_POP;
      count_nxt = count_r - CW'(1);
    end
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = e_char;
      char_valid_nxt = e_cv;
      expr_last_nxt  = e_last;
      err_out_nxt    = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lp_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      emitted_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lp_cnt_r    <= lp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      emitted_r   <= emitted_nxt || emit;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    ch_r         <= ch_nxt;
    last_r       <= last_nxt;
    err_r        <= err_nxt;
    out_char_r   <= out_char_nxt;
    char_valid_r <= char_valid_nxt;
    expr_last_r  <= expr_last_nxt;
    err_out_r    <= err_out_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_char   = out_char_r;
  assign out_chan.char_valid = char_valid_r;
  assign out_chan.expr_last  = expr_last_r;
  assign out_chan.error_code = err_out_r;

endmodule

// ===== rtl/core/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter. One ASCII character enters per word;
// end_of_expr on the last character flushes the operator stack and the final
// result word carries expr_last. The operator stack is a chain of STACK_DEPTH
// 8-bit cells, top at cell 0, shifting one place per push or pop; its contents
// are not cleared at reset, only the entry count is. Steps: the character is
// accepted, then in the stack step it pops the operators it displaces one at a
// time and is pushed or emitted, then comes the flush step; on the end mark the
// flush step pops the entries left on the stack one at a time, and a bare marker
// word stands for an end mark or error that gave no other word. Pops shift the
// cell chain one place, each result is registered in the single output register,
// and output back-pressure stalls the sequence. error_code is 1 for a ')' with no
// '(' on the stack and 2 when a push met a full stack; every word of that character carries it.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = ip2p_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ip2p_in_if.sink     in_chan,
  ip2p_out_if.source  out_chan
);

  ip2p_pkg::cell_ctl_t ctl;
  logic [7:0]          top;
  logic [7:0]          below;

  ip2p_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .top      (top),
    .below    (below),
    .ctl      (ctl)
  );

  ip2p_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .ctl   (ctl),
    .top   (top),
    .below (below)
  );

endmodule

// ===== rtl/core/ip2p_checker.sv =====
`include "infix_to_postfix_converter_assert.svh"

module ip2p_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_char_valid,
  input logic       out_expr_last,
  input logic [1:0] out_error_code
);

  `IP2P_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `IP2P_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "input taken while busy")
  `IP2P_ASSERT(a_bare_has_reason, out_valid && !out_char_valid |-> out_expr_last || out_error_code != ip2p_pkg::ERR_NONE, "bare word without end or error")
  `IP2P_ASSERT(a_err_code_legal, out_valid |-> out_error_code != 2'd3, "illegal error code")

endmodule

bind infix_to_postfix_converter ip2p_checker u_ip2p_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_char_valid (out_chan.char_valid),
  .out_expr_last  (out_chan.expr_last),
  .out_error_code (out_chan.error_code)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = ip2p_pkg::STACK_DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_CHARS = 500;
  localparam int N_DIR = 26;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       last;
    logic [1:0] err;
  } pf_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       typed;
    pf_word_t   w;
  } dir_row_t;

  localparam pf_word_t NO_W = '{8'h00, 1'b0, 1'b0, ip2p_pkg::ERR_NONE};

  // typed rows carry their single expected word; the rest go through the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{"A", 1'b0, 1'b1, '{"A", 1'b1, 1'b0, ip2p_pkg::ERR_NONE}},
    '{"z", 1'b0, 1'b1, '{"z", 1'b1, 1'b0, ip2p_pkg::ERR_NONE}},
    '{"0", 1'b1, 1'b1, '{"0", 1'b1, 1'b1, ip2p_pkg::ERR_NONE}},
    '{ip2p_pkg::CH_RPAREN, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ip2p_pkg::ERR_UNMATCHED}},
    '{ip2p_pkg::CH_RPAREN, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ip2p_pkg::ERR_UNMATCHED}},
    '{"9", 1'b0, 1'b1, '{"9", 1'b1, 1'b0, ip2p_pkg::ERR_NONE}},
    '{ip2p_pkg::CH_PLUS, 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_LPAREN, 1'b0, 1'b0, NO_W},
    '{"b", 1'b0, 1'b1, '{"b", 1'b1, 1'b0, ip2p_pkg::ERR_NONE}},
    '{ip2p_pkg::CH_MINUS, 1'b0, 1'b0, NO_W},
    '{"c", 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_STAR, 1'b0, 1'b0, NO_W},
    '{"d", 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_RPAREN, 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_SLASH, 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_CARET, 1'b0, 1'b0, NO_W},
    '{8'h00, 1'b0, 1'b0, NO_W},
    '{8'h80, 1'b0, 1'b0, NO_W},
    '{8'hFF, 1'b1, 1'b0, NO_W},
    '{ip2p_pkg::CH_LPAREN, 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_RPAREN, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ip2p_pkg::ERR_NONE}},
    '{"q", 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_STAR, 1'b0, 1'b0, NO_W},
    '{ip2p_pkg::CH_RPAREN, 1'b0, 1'b0, NO_W},
    '{"Z", 1'b1, 1'b0, NO_W},
    '{8'h7F, 1'b1, 1'b0, NO_W}
  };

  logic clk;
  logic rst_n;

  ip2p_in_if  in_if ();
  ip2p_out_if out_if ();

  infix_to_postfix_converter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [7:0] op_stk [$];
  int         max_depth;
  pf_word_t   postfix_q [$];

  int  mismatches;
  int  words_checked;
  int  unmatched_words;
  int  overflow_words;
  int  chars_sent;
  int  exprs_sent;
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic int op_rank(input logic [7:0] c);
    if (c == ip2p_pkg::CH_LPAREN) return 0;
    if (c == ip2p_pkg::CH_PLUS || c == ip2p_pkg::CH_MINUS) return 1;
    if (c == ip2p_pkg::CH_STAR || c == ip2p_pkg::CH_SLASH || c == ip2p_pkg::CH_CARET)
      return 2;
    return 3;
  endfunction

  function automatic void shunt_char(input logic [7:0] c, input logic eoe,
                                     output pf_word_t res [$]);
    logic [1:0] err;
    logic [7:0] t;
    bit         found;
    int         r;
    res = {};
    err = ip2p_pkg::ERR_NONE;
    found = 1'b0;
    if (is_operand(c)) begin
      res.push_back('{c, 1'b1, 1'b0, ip2p_pkg::ERR_NONE});
    end else if (c == ip2p_pkg::CH_LPAREN) begin
      if (op_stk.size() == DEPTH) begin
        err = ip2p_pkg::ERR_OVERFLOW;
      end else begin
        op_stk.push_back(c);
      end
    end else if (c == ip2p_pkg::CH_RPAREN) begin
      while (op_stk.size() > 0 && !found) begin
        t = op_stk.pop_back();
        if (t == ip2p_pkg::CH_LPAREN) found = 1'b1;
        else res.push_back('{t, 1'b1, 1'b0, ip2p_pkg::ERR_NONE});
      end
      if (!found) err = ip2p_pkg::ERR_UNMATCHED;
    end else begin
      r = op_rank(c);
      while (op_stk.size() > 0 && r <= op_rank(op_stk[$])) begin
        t = op_stk.pop_back();
        res.push_back('{t, 1'b1, 1'b0, ip2p_pkg::ERR_NONE});
      end
      if (op_stk.size() == DEPTH) begin
        err = ip2p_pkg::ERR_OVERFLOW;
      end else begin
        op_stk.push_back(c);
      end
    end
    if (op_stk.size() > max_depth) max_depth = op_stk.size();
    if (eoe) begin
      while (op_stk.size() > 0) begin
        t = op_stk.pop_back();
        res.push_back('{t, 1'b1, 1'b0, ip2p_pkg::ERR_NONE});
      end
    end
    if (res.size() == 0 && (eoe || err != ip2p_pkg::ERR_NONE)) res.push_back(NO_W);
    foreach (res[i]) res[i].err = err;
    if (eoe) res[res.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(2))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    logic [7:0] c;
    case ($urandom_range(9))
      0: c = ip2p_pkg::CH_PLUS;
      1: c = ip2p_pkg::CH_MINUS;
      2: c = ip2p_pkg::CH_STAR;
      3: c = ip2p_pkg::CH_SLASH;
      4: c = ip2p_pkg::CH_CARET;
      default: begin
        do c = 8'($urandom_range(255));
        while (is_operand(c) || c == ip2p_pkg::CH_LPAREN || c == ip2p_pkg::CH_RPAREN);
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t word %0d: %s", $time, words_checked, msg);
  endtask

  // called and returns just after a falling edge
  task automatic send_word(input logic [7:0] c, input logic eoe, input logic typed,
                           input pf_word_t typed_w);
    pf_word_t res [$];
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_char     <= c;
    in_if.end_of_expr <= eoe;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    shunt_char(c, eoe, res);
    if (typed) postfix_q.push_back(typed_w);
    else foreach (res[i]) postfix_q.push_back(res[i]);
    chars_sent++;
    if (eoe) exprs_sent++;
    @(negedge clk);
  endtask

  task automatic send_expression();
    logic [7:0] toks [$];
    int style;
    int nterm;
    int open;
    int k;
    style = $urandom_range(99);
    open = 0;
    if (style < 65) begin
      nterm = $urandom_range(1, 8);
      for (int i = 0; i < nterm; i++) begin
        if (i > 0) toks.push_back(rand_operator());
        k = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (k) begin
          toks.push_back(ip2p_pkg::CH_LPAREN);
          open++;
        end
        toks.push_back(rand_operand());
        if (open > 0 && $urandom_range(2) == 0) begin
          toks.push_back(ip2p_pkg::CH_RPAREN);
          open--;
        end
      end
      // broken forms: missing closers or a stray one
      if (style >= 50) begin
        if ($urandom_range(1) == 0) open = 0;
        else toks.push_back(ip2p_pkg::CH_RPAREN);
      end
      repeat (open) toks.push_back(ip2p_pkg::CH_RPAREN);
    end else if (style < 75) begin
      // deep nesting, may run into the full stack
      k = $urandom_range(28, 36);
      repeat (k) toks.push_back(ip2p_pkg::CH_LPAREN);
      toks.push_back(rand_operand());
      toks.push_back(rand_operator());
      toks.push_back(rand_operand());
      repeat ($urandom_range(k - 2, k + 2)) toks.push_back(ip2p_pkg::CH_RPAREN);
    end else begin
      k = $urandom_range(1, 10);
      repeat (k) toks.push_back(8'($urandom_range(255)));
    end
    foreach (toks[i]) begin
      if (style >= 75) send_word(toks[i], $urandom_range(3) == 0, 1'b0, NO_W);
      else send_word(toks[i], i == toks.size() - 1, 1'b0, NO_W);
    end
  endtask

  always @(posedge clk) begin : out_check
    pf_word_t got;
    pf_word_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.out_char, out_if.char_valid, out_if.expr_last, out_if.error_code};
      if (got.err == ip2p_pkg::ERR_UNMATCHED) unmatched_words++;
      if (got.err == ip2p_pkg::ERR_OVERFLOW) overflow_words++;
      if (postfix_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = postfix_q.pop_front();
        if (got.ch !== want.ch)
          report_mismatch($sformatf("out_char %h, want %h", got.ch, want.ch));
        if (got.cv !== want.cv)
          report_mismatch($sformatf("char_valid %b, want %b", got.cv, want.cv));
        if (got.last !== want.last)
          report_mismatch($sformatf("expr_last %b, want %b", got.last, want.last));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
      end
      words_checked++;
    end
  end

  initial begin : sink_side
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("stalled for %0d cycles, %0d words outstanding", quiet, postfix_q.size());
    $display("infix_to_postfix_converter regression: fail");
    $finish;
  end

  initial begin : main_seq
    bit hold_done;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_char = 8'h00;
    in_if.end_of_expr = 1'b0;
    hold_req = 1'b0;
    src_idle_pct = 36;
    sink_idle_pct = 36;
    max_depth = 0;
    mismatches = 0;
    words_checked = 0;
    unmatched_words = 0;
    overflow_words = 0;
    chars_sent = 0;
    exprs_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_word(dir_rows[i].ch, dir_rows[i].eoe, dir_rows[i].typed, dir_rows[i].w);

    while (chars_sent < N_CHARS) begin
      if (!hold_done && chars_sent >= 150) begin
        // receiver holds off while operands keep coming, then drain fully
        hold_req = 1'b1;
        repeat (40) send_word(rand_operand(), 1'b0, 1'b0, NO_W);
        in_if.valid <= 1'b0;
        while (postfix_q.size() != 0) @(negedge clk);
        @(negedge clk);
        hold_done = 1'b1;
      end
      src_idle_pct = (chars_sent >= 280 && chars_sent < 380) ? 0 : 36;
      sink_idle_pct = src_idle_pct;
      send_expression();
    end
    in_if.valid <= 1'b0;

    while (postfix_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d chars in %0d closed expressions, %0d postfix words checked, stack depth %0d",
             chars_sent, exprs_sent, words_checked, max_depth);
    $display("error words seen: %0d unmatched close, %0d overflow; %0d mismatches",
             unmatched_words, overflow_words, mismatches);
    if (mismatches == 0) begin
      $display("infix_to_postfix_converter regression: pass");
    end else begin
      $display("infix_to_postfix_converter regression: fail");
    end
    $finish;
  end

endmodule
